FILE: hdl/bounded_list_insert_remove_at_index_defines.svh
// assertion macros shared by the list controller and datapath
`ifndef BOUNDED_LIST_INSERT_REMOVE_AT_INDEX_DEFINES_SVH
`define BOUNDED_LIST_INSERT_REMOVE_AT_INDEX_DEFINES_SVH

// same-cycle implication
`define BLIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blir check failed");

// next-cycle implication
`define BLIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blir check failed");

`endif

FILE: hdl/blir_pkg.sv
// shared types and constants of the bounded list block
`default_nettype none

package blir_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VAL_W         = 32;
   localparam int IDX_W         = 7;
   localparam int CNT_OUT_W     = 7;

   typedef enum logic [1:0] {
      ACT_FRONT  = 2'd0,
      ACT_BACK   = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_DONE      = 2'd0,
      STS_BAD_INDEX = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       load_walk;
      logic       step;
      logic       insert;
      logic       unlink;
      logic       load_rsp;
      status_type res_status;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_remove;
      logic full;
      logic idx_ok;
   } stat_type;

endpackage

`default_nettype wire

FILE: hdl/blir_intf.sv
// request and response channel interfaces of the bounded list block
`default_nettype none

interface blir_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic signed [blir_pkg::VAL_W-1:0]   value;
   logic signed [blir_pkg::IDX_W-1:0]   index;

   modport source (output valid, output action, output value, output index, input ready);
   modport sink   (input valid, input action, input value, input index, output ready);
endinterface

interface blir_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            status;
   logic [blir_pkg::CNT_OUT_W-1:0]        count;
   logic signed [blir_pkg::VAL_W-1:0]     removed_value;

   modport source (output valid, output status, output count, output removed_value, input ready);
   modport sink   (input valid, input status, input count, input removed_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/blir_ctrl.sv
// controller state machine of the bounded list block
`default_nettype none
`include "bounded_list_insert_remove_at_index_defines.svh"

module blir_ctrl #(
   parameter int DEPTH = blir_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire blir_pkg::stat_type               stat,
   input  wire logic [$clog2(DEPTH+1)-1:0]       steps,
   output blir_pkg::cmd_type                     cmd
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DECODE   = 7'b0000010,
      ST_DISPATCH = 7'b0000100,
      ST_INSERT   = 7'b0001000,
      ST_WALK     = 7'b0010000,
      ST_UNLINK   = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          steps_ff, steps_in;
   blir_pkg::status_type   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      steps_in       = steps_ff;
      res_in         = res_ff;
      cmd            = '0;
      cmd.res_status = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            res_in = blir_pkg::STS_DONE;
            priority if (stat.is_insert) begin
               if (stat.full) begin
                  res_in   = blir_pkg::STS_FULL;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_INSERT;
               end
            end else if (stat.is_remove) begin
               if (!stat.idx_ok) begin
                  res_in   = blir_pkg::STS_BAD_INDEX;
                  state_in = ST_DONE;
               end else begin
                  cmd.load_walk = 1'b1;
                  steps_in      = steps;
                  state_in      = ST_WALK;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_DONE;
         end
         ST_WALK: begin
            if (steps_ff == '0) begin
               state_in = ST_UNLINK;
            end else begin
               cmd.step = 1'b1;
               steps_in = steps_ff - CW'(1);
            end
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      res_ff   <= res_in;
   end

   `BLIR_ASSERT_NEXT(walk_holds, clock, reset, (state_ff == ST_WALK) && (steps_ff != '0), state_ff == ST_WALK)
   `BLIR_ASSERT_NEXT(accept_decodes, clock, reset, req_valid && req_ready, state_ff == ST_DECODE)
   `BLIR_ASSERT_NEXT(done_presents, clock, reset, (state_ff == ST_DONE) && out_free, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

`default_nettype wire

FILE: hdl/blir_dpath.sv
// datapath of the bounded list block: slot memories, links, free slots, result register
`default_nettype none
`include "bounded_list_insert_remove_at_index_defines.svh"

module blir_dpath #(
   parameter int DEPTH = blir_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [1:0]                            req_action,
   input  wire logic signed [blir_pkg::VAL_W-1:0]     req_value,
   input  wire logic signed [blir_pkg::IDX_W-1:0]     req_index,
   input  wire blir_pkg::cmd_type                     cmd,
   output blir_pkg::stat_type                         stat,
   output logic [$clog2(DEPTH+1)-1:0]                 steps,
   output logic [1:0]                                 rsp_status,
   output logic [blir_pkg::CNT_OUT_W-1:0]             rsp_count,
   output logic signed [blir_pkg::VAL_W-1:0]          rsp_removed_value
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);
   localparam int VW = blir_pkg::VAL_W;
   localparam int IW = blir_pkg::IDX_W;
   localparam int PW = ((CW > IW) ? CW : IW) + 1;

   logic [VW-1:0]          val_mem   [DEPTH];
   logic [SW-1:0]          next_mem  [DEPTH];
   logic [SW-1:0]          prev_mem  [DEPTH];
   logic [SW-1:0]          stack_mem [DEPTH];

   logic [VW-1:0]          val_rd_ff;
   logic [SW-1:0]          next_rd_ff, prev_rd_ff, stack_rd_ff;

   logic [1:0]             action_ff;
   logic [VW-1:0]          value_ff;
   logic [IW-1:0]          index_ff;

   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          fresh_ff, fresh_in;
   logic [CW-1:0]          sp_ff, sp_in;
   logic [SW-1:0]          head_ff, head_in;
   logic [SW-1:0]          tail_ff, tail_in;
   logic [SW-1:0]          slot_ff, slot_in;
   logic [VW-1:0]          removed_ff;

   logic                   dec_ok_ff, dec_fwd_ff, dec_first_ff, dec_last_ff, dec_one_ff;
   logic                   dec_full_ff;
   logic [CW-1:0]          dec_steps_ff;

   logic signed [PW-1:0]   idx_x, cnt_x, sum_x, pos_x;
   logic                   idx_neg, ok_c, fwd_c;
   logic [CW-1:0]          pos_c, half_c, steps_c, last_pos_c;

   logic [CW-1:0]          sp_m1;
   logic [SW-1:0]          alloc_slot;
   logic                   list_empty, front;
   logic                   next_we, prev_we;
   logic [SW-1:0]          next_wa, next_wd, prev_wa, prev_wd;
   logic                   middle;

   // index decode
   always_comb begin
      idx_neg    = index_ff[IW-1];
      idx_x      = {{(PW-IW){index_ff[IW-1]}}, index_ff};
      cnt_x      = {{(PW-CW){1'b0}}, count_ff};
      sum_x      = cnt_x + idx_x;
      ok_c       = idx_neg ? !sum_x[PW-1] : (idx_x < cnt_x);
      pos_x      = idx_neg ? sum_x : idx_x;
      pos_c      = pos_x[CW-1:0];
      half_c     = count_ff >> 1;
      last_pos_c = count_ff - CW'(1);
      fwd_c      = pos_c < half_c;
      steps_c    = fwd_c ? pos_c : (last_pos_c - pos_c);
   end

   assign stat.is_insert = (action_ff == blir_pkg::ACT_FRONT) || (action_ff == blir_pkg::ACT_BACK);
   assign stat.is_remove = (action_ff == blir_pkg::ACT_REMOVE);
   assign stat.full      = dec_full_ff;
   assign stat.idx_ok    = dec_ok_ff;
   assign steps          = dec_steps_ff;

   // free slot: recycled slot from the stack, else a never-used one
   assign sp_m1      = sp_ff - CW'(1);
   assign alloc_slot = (sp_ff == '0) ? fresh_ff[SW-1:0] : stack_rd_ff;
   assign list_empty = (count_ff == '0);
   assign front      = (action_ff == blir_pkg::ACT_FRONT);
   assign middle     = !dec_one_ff && !dec_first_ff && !dec_last_ff;

   always_comb begin
      next_we = 1'b0;
      next_wa = alloc_slot;
      next_wd = head_ff;
      prev_we = 1'b0;
      prev_wa = head_ff;
      prev_wd = alloc_slot;
      if (cmd.insert && !list_empty) begin
         next_we = 1'b1;
         prev_we = 1'b1;
         if (!front) begin
            next_wa = tail_ff;
            next_wd = alloc_slot;
            prev_wa = alloc_slot;
            prev_wd = tail_ff;
         end
      end else if (cmd.unlink && middle) begin
         next_we = 1'b1;
         next_wa = prev_rd_ff;
         next_wd = next_rd_ff;
         prev_we = 1'b1;
         prev_wa = next_rd_ff;
         prev_wd = prev_rd_ff;
      end
   end

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      sp_in    = sp_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (cmd.load_walk) begin
         slot_in = dec_fwd_ff ? head_ff : tail_ff;
      end else if (cmd.step) begin
         slot_in = dec_fwd_ff ? next_rd_ff : prev_rd_ff;
      end
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
         if (sp_ff == '0) begin
            fresh_in = fresh_ff + CW'(1);
         end else begin
            sp_in = sp_m1;
         end
         if (list_empty) begin
            head_in = alloc_slot;
            tail_in = alloc_slot;
         end else if (front) begin
            head_in = alloc_slot;
         end else begin
            tail_in = alloc_slot;
         end
      end
      if (cmd.unlink) begin
         count_in = count_ff - CW'(1);
         sp_in    = sp_ff + CW'(1);
         priority if (dec_one_ff) begin
            head_in = '0;
            tail_in = '0;
         end else if (dec_first_ff) begin
            head_in = next_rd_ff;
         end else if (dec_last_ff) begin
            tail_in = prev_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fresh_ff <= '0;
         sp_ff    <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         count_ff <= count_in;
         fresh_ff <= fresh_in;
         sp_ff    <= sp_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.capture) begin
         action_ff  <= req_action;
         value_ff   <= req_value;
         index_ff   <= req_index;
         removed_ff <= '0;
      end
      if (cmd.decode) begin
         dec_ok_ff    <= ok_c;
         dec_fwd_ff   <= fwd_c;
         dec_first_ff <= (pos_c == '0);
         dec_last_ff  <= (pos_c == last_pos_c);
         dec_one_ff   <= (count_ff == CW'(1));
         dec_full_ff  <= (count_ff == CW'(DEPTH));
         dec_steps_ff <= steps_c;
      end
      if (cmd.unlink) begin
         removed_ff <= val_rd_ff;
      end
      if (cmd.load_rsp) begin
         rsp_status        <= cmd.res_status;
         rsp_count         <= blir_pkg::CNT_OUT_W'(count_ff);
         rsp_removed_value <= removed_ff;
      end
   end

   // slot memories, read data follows the current walk slot
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         val_mem[alloc_slot] <= value_ff;
      end
      val_rd_ff <= val_mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_rd_ff <= next_mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      prev_rd_ff <= prev_mem[slot_in];
   end

   // recycled slot stack
   always_ff @(posedge clock) begin
      if (cmd.unlink) begin
         stack_mem[sp_ff[SW-1:0]] <= slot_ff;
      end
      stack_rd_ff <= stack_mem[sp_m1[SW-1:0]];
   end

   `BLIR_ASSERT_NOW(slots_balance, clock, reset, 1'b1, count_ff == (fresh_ff - sp_ff))
   `BLIR_ASSERT_NOW(no_insert_when_full, clock, reset, cmd.insert, count_ff != CW'(DEPTH))
   `BLIR_ASSERT_NEXT(unlink_shrinks, clock, reset, cmd.unlink, count_ff == ($past(count_ff) - CW'(1)))

endmodule

`default_nettype wire

FILE: hdl/bounded_list_insert_remove_at_index.sv
// Bounded ordered list of up to DEPTH signed 32-bit values with insert at front or back
// and removal at a signed index (negative counts from the end). Each request item yields
// one response item with status, the new count (low 7 bits) and the removed value. The
// block takes one item at a time. A removal walks k link hops from the nearer end of the
// list (at most count/2) before it unlinks the entry, and the walk reads one entry of the
// link memory per cycle. A finished response waits in an output register, so a stalled
// response channel holds only the item that is about to finish. No clearing pass is
// needed after reset: unused slots come from a fill count and freed slots are recycled
// through a stack memory, so the block is ready right after reset.
`default_nettype none

module bounded_list_insert_remove_at_index #(
   parameter int DEPTH = blir_pkg::DEPTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   blir_req_if.sink    req_ch,
   blir_rsp_if.source  rsp_ch
);

   blir_pkg::cmd_type              cmd;
   blir_pkg::stat_type             stat;
   logic [$clog2(DEPTH+1)-1:0]     steps;

   blir_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .steps     (steps),
      .cmd       (cmd)
   );

   blir_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_ch.action),
      .req_value         (req_ch.value),
      .req_index         (req_ch.index),
      .cmd               (cmd),
      .stat              (stat),
      .steps             (steps),
      .rsp_status        (rsp_ch.status),
      .rsp_count         (rsp_ch.count),
      .rsp_removed_value (rsp_ch.removed_value)
   );

endmodule

`default_nettype wire

FILE: tb/sv/bounded_list_insert_remove_at_index_test.sv
// self-checking testbench of the bounded list block: directed table, then random traffic
`timescale 1ns / 1ps

module bounded_list_insert_remove_at_index_test;

   localparam int DEPTH         = blir_pkg::DEPTH_DEFAULT;
   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_ITEMS  = 750;
   localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 60;

   typedef struct packed {
      blir_pkg::status_type status;
      logic [6:0]           count;
      logic signed [31:0]   removed;
   } outcome_type;

   typedef struct {
      blir_pkg::action_type act;
      logic [31:0]          val;
      int                   idx;
      bit                   typed;
      blir_pkg::status_type status;
      int                   count;
      logic [31:0]          removed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blir_req_if req_bus ();
   blir_rsp_if rsp_bus ();

   bounded_list_insert_remove_at_index #(.DEPTH(DEPTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   logic signed [31:0] list_values [$];
   outcome_type        expected_q [$];
   int                 errors = 0;
   int                 cycles = 0;
   int                 items_sent = 0;
   int                 sender_idle_pct = 26;
   int                 receiver_idle_pct = 51;

   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,   0, 1'b1, blir_pkg::STS_BAD_INDEX, 0, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h1234_5678,  -1, 1'b1, blir_pkg::STS_BAD_INDEX, 0, 32'h0},
      '{blir_pkg::ACT_NONE,   32'hdead_beef,   5, 1'b1, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_FRONT,  32'h7fff_ffff, -64, 1'b1, blir_pkg::STS_DONE,      1, 32'h0},
      '{blir_pkg::ACT_BACK,   32'h8000_0000,  63, 1'b1, blir_pkg::STS_DONE,      2, 32'h0},
      '{blir_pkg::ACT_FRONT,  32'h0000_0000,   0, 1'b1, blir_pkg::STS_DONE,      3, 32'h0},
      '{blir_pkg::ACT_BACK,   32'hffff_ffff,  -1, 1'b1, blir_pkg::STS_DONE,      4, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,  63, 1'b1, blir_pkg::STS_BAD_INDEX, 4, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'hffff_ffff, -64, 1'b1, blir_pkg::STS_BAD_INDEX, 4, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,   4, 1'b1, blir_pkg::STS_BAD_INDEX, 4, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,  -5, 1'b1, blir_pkg::STS_BAD_INDEX, 4, 32'h0},
      '{blir_pkg::ACT_NONE,   32'h8000_0000, -64, 1'b1, blir_pkg::STS_DONE,      4, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,  -4, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,   1, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,  -1, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,   0, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_BACK,   32'h5555_5555,   0, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_BACK,   32'haaaa_aaaa,   0, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_FRONT,  32'h0000_0001,   0, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,   1, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,  -2, 1'b0, blir_pkg::STS_DONE,      0, 32'h0},
      '{blir_pkg::ACT_REMOVE, 32'h0000_0000,   0, 1'b0, blir_pkg::STS_DONE,      0, 32'h0}
   };

   // applies one item to the shadow list and returns what the block should answer
   function automatic outcome_type apply_list_op(blir_pkg::action_type act, logic [31:0] val,
                                                 logic signed [6:0] idx);
      outcome_type r;
      int          n;
      int          i;
      int          pos;
      r.status  = blir_pkg::STS_DONE;
      r.removed = '0;
      n = list_values.size();
      i = idx;
      case (act)
         blir_pkg::ACT_FRONT, blir_pkg::ACT_BACK: begin
            if (n >= DEPTH) begin
               r.status = blir_pkg::STS_FULL;
            end else if (act == blir_pkg::ACT_FRONT) begin
               list_values.push_front(val);
            end else begin
               list_values.push_back(val);
            end
         end
         blir_pkg::ACT_REMOVE: begin
            if (i < -n || i >= n) begin
               r.status = blir_pkg::STS_BAD_INDEX;
            end else begin
               pos = (i < 0) ? n + i : i;
               r.removed = list_values[pos];
               list_values.delete(pos);
            end
         end
         default: ;
      endcase
      r.count = 7'(list_values.size());
      return r;
   endfunction

   task automatic note_mismatch(string what, outcome_type want, outcome_type got);
      errors++;
      if (errors <= 10)
         $display({"mismatch (%s) at cycle %0d: expected status %0d count %0d removed %0d,",
                   " got status %0d count %0d removed %0d"},
                  what, cycles, want.status, want.count, want.removed,
                  got.status, got.count, got.removed);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(blir_pkg::action_type act, logic [31:0] val, int idx, bit typed,
                            outcome_type typed_out);
      outcome_type predicted;
      if (items_sent < TOTAL_ITEMS / 3) begin
         sender_idle_pct   = 26;
         receiver_idle_pct = 51;
      end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
         sender_idle_pct   = 51;
         receiver_idle_pct = 26;
      end else begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= val;
      req_bus.index  <= idx[6:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_list_op(act, val, idx[6:0]);
      expected_q.push_back(typed ? typed_out : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status  = blir_pkg::status_type'(rsp_bus.status);
         got.count   = rsp_bus.count;
         got.removed = rsp_bus.removed_value;
         if (expected_q.size() == 0) begin
            note_mismatch("unexpected item", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got.status !== want.status)   note_mismatch("status", want, got);
            if (got.count !== want.count)     note_mismatch("count", want, got);
            if (got.removed !== want.removed) note_mismatch("removed_value", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** bounded_list_insert_remove_at_index: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      outcome_type          typed_out;
      blir_pkg::action_type act;
      logic [31:0]          val;
      int                   idx;
      int                   n;
      int                   pos;
      int                   roll;
      bit                   draining;
      req_bus.valid  = 1'b0;
      req_bus.action = '0;
      req_bus.value  = '0;
      req_bus.index  = '0;
      draining = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         typed_out.status  = directed_rows[r].status;
         typed_out.count   = 7'(directed_rows[r].count);
         typed_out.removed = directed_rows[r].removed;
         send_item(directed_rows[r].act, directed_rows[r].val, directed_rows[r].idx,
                   directed_rows[r].typed, typed_out);
      end

      // fill toward full, hammer it, then drain to empty, and again
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         n = list_values.size();
         if (n == DEPTH && $urandom_range(7) == 0) draining = 1'b1;
         if (n == 0) draining = 1'b0;
         roll = $urandom_range(99);
         if (roll < 4) begin
            act = blir_pkg::ACT_NONE;
         end else if (roll < (draining ? 30 : 75)) begin
            act = $urandom_range(1) ? blir_pkg::ACT_BACK : blir_pkg::ACT_FRONT;
         end else begin
            act = blir_pkg::ACT_REMOVE;
         end
         val = $urandom;
         if ($urandom_range(15) == 0) begin
            case ($urandom_range(3))
               0: val = 32'h8000_0000;
               1: val = 32'h7fff_ffff;
               2: val = 32'h0000_0000;
               default: val = 32'hffff_ffff;
            endcase
         end
         roll = $urandom_range(99);
         if (act == blir_pkg::ACT_REMOVE && n > 0 && roll < 80) begin
            pos = $urandom_range(n - 1);
            idx = $urandom_range(1) ? pos : pos - n;
         end else if (roll < 90) begin
            case ($urandom_range(3))
               0: idx = -64;
               1: idx = 63;
               2: idx = (n > 63) ? 63 : n;
               default: idx = (n > 63) ? -64 : -n - 1;
            endcase
         end else begin
            idx = $urandom_range(127);
         end
         send_item(act, val, idx, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("** bounded_list_insert_remove_at_index: PASSED **");
      end else begin
         $display("** bounded_list_insert_remove_at_index: FAILED **");
      end
      $finish;
   end

endmodule
